// ===== design/rvx_pkg.sv =====
// ----------------------------------------------------------------------------
// rvx_pkg
// types and constants shared by the rv32i execute unit modules
// ----------------------------------------------------------------------------
package rvx_pkg;

  localparam logic [3:0] CMD_LOAD  = 4'd0;
  localparam logic [3:0] CMD_OPIMM = 4'd1;
  localparam logic [3:0] CMD_AUIPC = 4'd2;
  localparam logic [3:0] CMD_STORE = 4'd3;
  localparam logic [3:0] CMD_OP    = 4'd4;
  localparam logic [3:0] CMD_BRANCH = 4'd5;
  localparam logic [3:0] CMD_LUI   = 4'd6;
  localparam logic [3:0] CMD_JALR  = 4'd7;
  localparam logic [3:0] CMD_JAL   = 4'd8;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_ILL = 2'd1;
  localparam logic [1:0] STAT_MIS = 2'd2;

  localparam logic [31:0] PC_RESET = 32'h8000_0000;

  typedef struct packed {
    logic [3:0]         cmd;
    logic [2:0]         funct3;
    logic               alt_bit;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic signed [31:0] immediate;
    logic               illegal;
  } item_t;

endpackage

// ===== design/rvx_if.sv =====
// ----------------------------------------------------------------------------
// rvx channel interfaces
// valid/ready channels for instructions, results and configuration
// ----------------------------------------------------------------------------
interface rvx_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         cmd;
  logic [2:0]         funct3;
  logic               alt_bit;
  logic [4:0]         dest_reg;
  logic [4:0]         src1_reg;
  logic [4:0]         src2_reg;
  logic signed [31:0] immediate;
  modport source (output valid, cmd, funct3, alt_bit, dest_reg, src1_reg, src2_reg,
                  immediate, input ready);
  modport sink (input valid, cmd, funct3, alt_bit, dest_reg, src1_reg, src2_reg,
                immediate, output ready);
endinterface

interface rvx_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        reg_written;
  logic [4:0]  written_index;
  logic [31:0] written_value;
  logic [31:0] next_pc;
  modport source (output valid, status, reg_written, written_index, written_value, next_pc,
                  input ready);
  modport sink (input valid, status, reg_written, written_index, written_value, next_pc,
                output ready);
endinterface

interface rvx_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== design/rvx_front.sv =====
// ----------------------------------------------------------------------------
// rvx_front
// accepts decoded instructions, flags illegal ones, two-entry queue
// ----------------------------------------------------------------------------
module rvx_front
  import rvx_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  blocked,
  rvx_in_if.sink in_ch,
  output logic  q_valid,
  input  logic  q_ready,
  output item_t q_item
);

  item_t       fifo_r [2];
  logic        wptr_r, wptr_nxt;
  logic        rptr_r, rptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push, pop, illegal;

  // classify: unknown class or reserved funct3
  always_comb begin
    illegal = 1'b0;
    case (in_ch.cmd)
      CMD_LOAD:   illegal = (in_ch.funct3 == 3'd3) || (in_ch.funct3 == 3'd6) ||
                            (in_ch.funct3 == 3'd7);
      CMD_STORE:  illegal = (in_ch.funct3 > 3'd2);
      CMD_BRANCH: illegal = (in_ch.funct3 == 3'd2) || (in_ch.funct3 == 3'd3);
      CMD_OPIMM, CMD_AUIPC, CMD_OP, CMD_LUI, CMD_JALR, CMD_JAL: illegal = 1'b0;
      default:    illegal = 1'b1;
    endcase
  end

  assign in_ch.ready = (cnt_r != 2'd2) && !blocked;
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign pop         = q_valid && q_ready;
  assign q_item      = fifo_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wptr_r] <= '{cmd: in_ch.cmd, funct3: in_ch.funct3, alt_bit: in_ch.alt_bit,
                          dest_reg: in_ch.dest_reg, src1_reg: in_ch.src1_reg,
                          src2_reg: in_ch.src2_reg, immediate: in_ch.immediate,
                          illegal: illegal};
    end
  end

endmodule

// ===== design/rvx_back.sv =====
// ----------------------------------------------------------------------------
// rvx_back
// executes one instruction at a time against register file, pc and data memory
// ----------------------------------------------------------------------------
module rvx_back
  import rvx_pkg::*;
#(
  parameter int MEM_BYTES = 4096
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  output logic    q_ready,
  input  item_t   q_item,
  input  logic    cfg_we,
  input  logic [31:0] cfg_data,
  output logic    clearing,
  rvx_out_if.source out_ch
);

  localparam int AW   = $clog2(MEM_BYTES);
  localparam int ROWS = MEM_BYTES / 4;
  localparam int RW   = AW - 2;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EX   = 2'd1;
  localparam logic [1:0] S_LD   = 2'd2;
  localparam logic [1:0] S_CLR  = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [RW-1:0] clr_cnt_r, clr_cnt_nxt;
  item_t       cur_r;
  logic [31:0] pc_r;
  logic [31:0] vld_r;
  logic [31:0] rf_a [32];
  logic [31:0] rf_b [32];
  logic [31:0] a_raw_r, b_raw_r;
  logic        a_vld_r, b_vld_r;
  logic [31:0] a, b, imm, seq, alu_b, alu_res, val, next;
  logic [31:0] addr, ld_val;
  logic [1:0]  lo_r;
  logic [7:0]  mdat_r [4];
  logic [7:0]  lbyte [4];
  logic [1:0]  status;
  logic        wr, lt_s, lt_u, take, is_ld, fin, st_en, alt_sra, alt_sub, chk;
  logic [4:0]  sh;

  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic        out_wr_r;
  logic [4:0]  out_idx_r;
  logic [31:0] out_val_r, out_pc_r;

  assign clearing = (state_r == S_CLR);
  assign q_ready  = (state_r == S_IDLE);
  assign a   = a_vld_r ? a_raw_r : 32'd0;
  assign b   = b_vld_r ? b_raw_r : 32'd0;
  assign imm = cur_r.immediate;
  assign seq = pc_r + 32'd4;
  assign is_ld = (cur_r.cmd == CMD_LOAD) && !cur_r.illegal;
  assign addr = a + imm;

  // alu shared by op-imm and op
  always_comb begin
    alu_b   = (cur_r.cmd == CMD_OP) ? b : imm;
    alt_sub = (cur_r.cmd == CMD_OP) && cur_r.alt_bit;
    alt_sra = (cur_r.cmd == CMD_OP) ? cur_r.alt_bit : imm[10];
    sh      = alu_b[4:0];
    lt_s    = $signed(a) < $signed(alu_b);
    lt_u    = a < alu_b;
    case (cur_r.funct3)
      3'd0:    alu_res = alt_sub ? a - alu_b : a + alu_b;
      3'd1:    alu_res = a << sh;
      3'd2:    alu_res = {31'd0, lt_s};
      3'd3:    alu_res = {31'd0, lt_u};
      3'd4:    alu_res = a ^ alu_b;
      3'd5:    alu_res = alt_sra ? 32'($signed(a) >>> sh) : a >> sh;
      3'd6:    alu_res = a | alu_b;
      default: alu_res = a & alu_b;
    endcase
  end

  // load data assembly, byte k sits in bank lo+k
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      lbyte[k] = mdat_r[2'(lo_r + 2'(k))];
    end
    case (cur_r.funct3)
      3'd0:    ld_val = {{24{lbyte[0][7]}}, lbyte[0]};
      3'd1:    ld_val = {{16{lbyte[1][7]}}, lbyte[1], lbyte[0]};
      3'd4:    ld_val = {24'd0, lbyte[0]};
      3'd5:    ld_val = {16'd0, lbyte[1], lbyte[0]};
      default: ld_val = {lbyte[3], lbyte[2], lbyte[1], lbyte[0]};
    endcase
  end

  always_comb begin
    status = cur_r.illegal ? STAT_ILL : STAT_OK;
    wr     = 1'b0;
    val    = 32'd0;
    next   = seq;
    take   = 1'b0;
    chk    = 1'b0;
    case (cur_r.funct3)
      3'd0:    take = (a == b);
      3'd1:    take = (a != b);
      3'd4:    take = $signed(a) < $signed(b);
      3'd5:    take = !($signed(a) < $signed(b));
      3'd6:    take = a < b;
      default: take = a >= b;
    endcase
    case (cur_r.cmd)
      CMD_LOAD:  begin wr = 1'b1; val = ld_val; end
      CMD_OPIMM, CMD_OP: begin wr = 1'b1; val = alu_res; end
      CMD_AUIPC: begin wr = 1'b1; val = pc_r + imm; end
      CMD_LUI:   begin wr = 1'b1; val = imm; end
      CMD_BRANCH: begin
        if (take && !cur_r.illegal) begin
          next = pc_r + imm;
          chk  = 1'b1;
        end
      end
      CMD_JALR: begin wr = 1'b1; val = seq; next = {addr[31:1], 1'b0}; chk = 1'b1; end
      CMD_JAL:  begin wr = 1'b1; val = seq; next = pc_r + imm; chk = 1'b1; end
      default: ;
    endcase
    // only a taken target is checked for alignment
    if (status == STAT_OK && chk && next[1:0] != 2'b00) begin
      status = STAT_MIS;
    end
    if (status != STAT_OK) begin
      next = pc_r;
    end
    if (status != STAT_OK || cur_r.dest_reg == 5'd0) begin
      wr  = 1'b0;
    end
    if (!wr) begin
      val = 32'd0;
    end
  end

  assign fin = ((state_r == S_EX && !is_ld) || state_r == S_LD) &&
               (!out_valid_r || out_ch.ready);
  assign st_en = fin && (cur_r.cmd == CMD_STORE) && (status == STAT_OK);

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      S_CLR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == RW'(ROWS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: if (q_valid) state_nxt = S_EX;
      S_EX: begin
        if (is_ld) state_nxt = S_LD;
        else if (fin) state_nxt = S_IDLE;
      end
      S_LD: if (fin) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_cnt_r <= '0;
      pc_r      <= PC_RESET;
      vld_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (cfg_we) pc_r <= cfg_data;
      else if (fin) pc_r <= next;
      if (fin && wr) vld_r[cur_r.dest_reg] <= 1'b1;
      if (fin) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // register file, one copy per read port
  always_ff @(posedge clk) begin
    if (fin && wr) begin
      rf_a[cur_r.dest_reg] <= val;
      rf_b[cur_r.dest_reg] <= val;
    end
    if (q_valid && q_ready) begin
      cur_r   <= q_item;
      a_raw_r <= rf_a[q_item.src1_reg];
      b_raw_r <= rf_b[q_item.src2_reg];
      a_vld_r <= vld_r[q_item.src1_reg];
      b_vld_r <= vld_r[q_item.src2_reg];
    end
    if (state_r == S_EX) lo_r <= addr[1:0];
    if (fin) begin
      out_status_r <= status;
      out_wr_r     <= wr;
      out_idx_r    <= wr ? cur_r.dest_reg : 5'd0;
      out_val_r    <= val;
      out_pc_r     <= next;
    end
  end

  // data memory: four byte banks, byte address wraps at MEM_BYTES
  for (genvar g = 0; g < 4; g++) begin : g_bank
    logic [7:0]    mem [ROWS];
    logic [1:0]    k;
    logic [AW-1:0] idx;
    logic [RW-1:0] row;
    logic          we;
    logic [7:0]    wdat;

    always_comb begin
      k   = 2'(g) - addr[1:0];
      idx = addr[AW-1:0] + AW'(k);
      row = idx[AW-1:2];
      case (cur_r.funct3)
        3'd0:    we = st_en && (k == 2'd0);
        3'd1:    we = st_en && (k <= 2'd1);
        default: we = st_en;
      endcase
      case (k)
        2'd0:    wdat = b[7:0];
        2'd1:    wdat = b[15:8];
        2'd2:    wdat = b[23:16];
        default: wdat = b[31:24];
      endcase
    end

    always_ff @(posedge clk) begin
      if (state_r == S_CLR) mem[clr_cnt_r] <= 8'd0;
      else if (we) mem[row] <= wdat;
      if (state_r == S_EX && is_ld) mdat_r[g] <= mem[row];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.reg_written   = out_wr_r;
  assign out_ch.written_index = out_idx_r;
  assign out_ch.written_value = out_val_r;
  assign out_ch.next_pc       = out_pc_r;

endmodule

// ===== design/rv32i_execute_unit.sv =====
// ----------------------------------------------------------------------------
// rv32i_execute_unit
// rv32i integer execute unit with register file, pc and byte data memory
// ----------------------------------------------------------------------------
// executes one decoded rv32i instruction per in_ transaction and returns one
// out_ transaction with status, register write and next pc. alu, lui, auipc,
// store, branch and jump instructions go through a register file read, then
// execute and write back; loads go through register read, data memory read
// and write back, set by the synchronous register file and data memory ports. a
// two-entry queue in front and an output register behind let both sides stall
// independently. after reset the data memory is swept to zero and no
// instruction is taken meanwhile; cfg_ writes load the pc at any time and are
// meant for idle periods
module rv32i_execute_unit
  import rvx_pkg::*;
#(
  parameter int MEM_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  rvx_in_if.sink      in_ch,
  rvx_out_if.source   out_ch,
  rvx_cfg_if.sink     cfg_ch
);

  logic  q_valid, q_ready, clearing;
  item_t q_item;

  // pc load is always accepted
  assign cfg_ch.ready = 1'b1;

  // front: accept and classify
  rvx_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .blocked (clearing),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  // back: execute and commit
  rvx_back #(.MEM_BYTES(MEM_BYTES)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .cfg_we   (cfg_ch.valid),
    .cfg_data (cfg_ch.data),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

endmodule

// ===== design/rvx_checker.sv =====
// ----------------------------------------------------------------------------
// rvx_checker
// port-level checks for the rv32i execute unit
// ----------------------------------------------------------------------------
module rvx_checker
  import rvx_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic        out_reg_written,
  input logic [4:0]  out_written_index,
  input logic [31:0] out_written_value,
  input logic [31:0] out_next_pc
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_pc) &&
    $stable(out_written_value))
    else $error("result changed while stalled");

  // an error never writes a register
  a_err_nowr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK |-> !out_reg_written)
    else $error("register written on error");

  // no write reports zero index and value
  a_nowr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reg_written |-> out_written_index == 5'd0 &&
    out_written_value == 32'd0)
    else $error("nonzero write fields without write");

  // x0 is never reported as written
  a_no_x0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reg_written |-> out_written_index != 5'd0)
    else $error("write to x0 reported");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result right after reset");

endmodule

bind rv32i_execute_unit rvx_checker u_rvx_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_status        (out_ch.status),
  .out_reg_written   (out_ch.reg_written),
  .out_written_index (out_ch.written_index),
  .out_written_value (out_ch.written_value),
  .out_next_pc       (out_ch.next_pc)
);
